// ----- rtl/ltrd_pkg.sv -----
package ltrd_pkg;

    localparam int GEN_COUNT = 64;
    localparam int IDX_W     = 6;
    localparam int MULT_W    = 15;
    localparam int STATE_W   = 16;
    localparam int PRIME_W   = 16;
    localparam int FRAC_W    = 32;

    localparam int MUL_CNT_W = $clog2(MULT_W);
    localparam int DIV_CNT_W = $clog2(FRAC_W);

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DRAW = 1'b1;

    // prime modulus of each generator, 46337 down to 45631
    localparam logic [PRIME_W-1:0] PRIME_TAB [GEN_COUNT] = '{
        16'd46337, 16'd46327, 16'd46309, 16'd46307, 16'd46301, 16'd46279, 16'd46273, 16'd46271,
        16'd46261, 16'd46237, 16'd46229, 16'd46219, 16'd46199, 16'd46187, 16'd46183, 16'd46181,
        16'd46171, 16'd46153, 16'd46147, 16'd46141, 16'd46133, 16'd46103, 16'd46099, 16'd46093,
        16'd46091, 16'd46073, 16'd46061, 16'd46051, 16'd46049, 16'd46027, 16'd46021, 16'd45989,
        16'd45979, 16'd45971, 16'd45959, 16'd45953, 16'd45949, 16'd45943, 16'd45893, 16'd45887,
        16'd45869, 16'd45863, 16'd45853, 16'd45841, 16'd45833, 16'd45827, 16'd45823, 16'd45821,
        16'd45817, 16'd45779, 16'd45767, 16'd45763, 16'd45757, 16'd45751, 16'd45737, 16'd45707,
        16'd45697, 16'd45691, 16'd45677, 16'd45673, 16'd45667, 16'd45659, 16'd45641, 16'd45631
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_IDX,
        ST_LOAD,
        ST_MUL,
        ST_DIV,
        ST_PUSH
    } t_state;

    typedef struct packed {
        logic                we_state;
        logic                we_mult;
        logic [IDX_W-1:0]    addr;
        logic [STATE_W-1:0]  state;
        logic [MULT_W-1:0]   mult;
    } t_tbl_wr;

endpackage

// ----- rtl/lehmer_table_random_draw.sv -----
// channel | handshake                  | beat
// in      | i_in_valid / o_in_stall    | i_cmd, i_entry_index, i_entry_multiplier, i_entry_state
// out     | o_out_valid / i_out_stall  | o_generator_index, o_new_state, o_modulus, o_fraction
//
// a load beat is written to the tables at once and the control stays idle
// a draw beat runs from accept to output valid through two table reads, 15 steps of
// the bit-serial modular multiplier, 32 steps of the shift-subtract fraction divider,
// a done strobe after each unit and one handoff; then the next beat can be taken
// one item is in work at a time; the output register frees the input side
// synchronous active-low reset clears the pointer and control, tables are not cleared
// a stalled output holds its beat; a finished draw waits until the register is free
module lehmer_table_random_draw (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_cmd,
    input  logic [ltrd_pkg::IDX_W-1:0]   i_entry_index,
    input  logic [ltrd_pkg::MULT_W-1:0]  i_entry_multiplier,
    input  logic [ltrd_pkg::STATE_W-1:0] i_entry_state,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [ltrd_pkg::IDX_W-1:0]   o_generator_index,
    output logic [ltrd_pkg::STATE_W-1:0] o_new_state,
    output logic [ltrd_pkg::PRIME_W-1:0] o_modulus,
    output logic [ltrd_pkg::FRAC_W-1:0]  o_fraction
);
    import ltrd_pkg::*;

    t_state              r_state;
    t_state              n_state;

    logic [IDX_W-1:0]    r_ptr;
    logic [IDX_W-1:0]    r_idx;
    logic [PRIME_W-1:0]  r_prime;

    logic                r_o_valid;
    logic [IDX_W-1:0]    r_o_idx;
    logic [STATE_W-1:0]  r_o_state;
    logic [PRIME_W-1:0]  r_o_prime;
    logic [FRAC_W-1:0]   r_o_frac;

    logic                w_in_acc;
    logic                w_load_ok;
    logic                w_push;
    t_tbl_wr             w_wr;
    logic [IDX_W-1:0]    w_rd_addr;
    logic [STATE_W-1:0]  w_rd_state;
    logic [MULT_W-1:0]   w_rd_mult;
    logic                w_mul_start;
    logic                w_mul_done;
    logic [STATE_W-1:0]  w_mul_result;
    logic                w_div_start;
    logic                w_div_done;
    logic [FRAC_W-1:0]   w_div_quot;

    assign w_in_acc  = i_in_valid && (r_state == ST_IDLE);
    assign w_load_ok = (int'(i_entry_index) < GEN_COUNT);
    assign w_push    = (r_state == ST_PUSH) && (!r_o_valid || !i_out_stall);

    ltrd_table u_table (
        .i_clk      (i_clk),
        .i_wr       (w_wr),
        .i_rd_addr  (w_rd_addr),
        .o_rd_state (w_rd_state),
        .o_rd_mult  (w_rd_mult)
    );

    ltrd_modmul u_modmul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mul_start),
        .i_state  (w_rd_state),
        .i_mult   (w_rd_mult),
        .i_prime  (r_prime),
        .o_done   (w_mul_done),
        .o_result (w_mul_result)
    );

    ltrd_fracdiv u_fracdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_mul_result),
        .i_prime (r_prime),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_stall  = 1'b1;
        w_rd_addr   = r_ptr;
        w_mul_start = 1'b0;
        w_div_start = 1'b0;
        w_wr        = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (w_in_acc) begin
                    if (i_cmd == CMD_DRAW) begin
                        n_state = ST_IDX;
                    end else if (w_load_ok) begin
                        w_wr.we_state = 1'b1;
                        w_wr.we_mult  = 1'b1;
                        w_wr.addr     = i_entry_index;
                        w_wr.state    = i_entry_state;
                        w_wr.mult     = i_entry_multiplier;
                    end
                end
            end
            ST_IDX: begin
                // state at the pointer, mod the generator count, picks the entry
                w_rd_addr = w_rd_state[IDX_W-1:0];
                n_state   = ST_LOAD;
            end
            ST_LOAD: begin
                w_mul_start = 1'b1;
                n_state     = ST_MUL;
            end
            ST_MUL: begin
                if (w_mul_done) begin
                    w_wr.we_state = 1'b1;
                    w_wr.addr     = r_idx;
                    w_wr.state    = w_mul_result;
                    w_div_start   = 1'b1;
                    n_state       = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (w_push) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (w_in_acc && (i_cmd == CMD_LOAD) && w_load_ok) begin
            r_ptr <= '0;
        end else if ((r_state == ST_MUL) && w_mul_done) begin
            r_ptr <= r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDX) begin
            r_idx   <= w_rd_state[IDX_W-1:0];
            r_prime <= PRIME_TAB[w_rd_state[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_push) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_o_idx   <= r_idx;
            r_o_state <= w_mul_result;
            r_o_prime <= r_prime;
            r_o_frac  <= w_div_quot;
        end
    end

    assign o_out_valid       = r_o_valid;
    assign o_generator_index = r_o_idx;
    assign o_new_state       = r_o_state;
    assign o_modulus         = r_o_prime;
    assign o_fraction        = r_o_frac;

endmodule

// ----- rtl/ltrd_table.sv -----
module ltrd_table (
    input  logic                     i_clk,
    input  ltrd_pkg::t_tbl_wr        i_wr,
    input  logic [ltrd_pkg::IDX_W-1:0]   i_rd_addr,
    output logic [ltrd_pkg::STATE_W-1:0] o_rd_state,
    output logic [ltrd_pkg::MULT_W-1:0]  o_rd_mult
);
    import ltrd_pkg::*;

    logic [STATE_W-1:0] r_state_mem [GEN_COUNT];
    logic [MULT_W-1:0]  r_mult_mem  [GEN_COUNT];

    always_ff @(posedge i_clk) begin
        if (i_wr.we_state) begin
            r_state_mem[i_wr.addr] <= i_wr.state;
        end
        if (i_wr.we_mult) begin
            r_mult_mem[i_wr.addr] <= i_wr.mult;
        end
        o_rd_state <= r_state_mem[i_rd_addr];
        o_rd_mult  <= r_mult_mem[i_rd_addr];
    end

endmodule

// ----- rtl/ltrd_modmul.sv -----
module ltrd_modmul (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ltrd_pkg::STATE_W-1:0] i_state,
    input  logic [ltrd_pkg::MULT_W-1:0]  i_mult,
    input  logic [ltrd_pkg::PRIME_W-1:0] i_prime,
    output logic                         o_done,
    output logic [ltrd_pkg::STATE_W-1:0] o_result
);
    import ltrd_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic [MULT_W-1:0]    r_mshift;
    logic [STATE_W-1:0]   r_s;
    logic [PRIME_W-1:0]   r_p;
    logic [STATE_W-1:0]   r_acc;

    logic [STATE_W+1:0]   w_t;
    logic [STATE_W+1:0]   w_p1;
    logic [STATE_W+1:0]   w_p2;
    logic [STATE_W+1:0]   w_red;

    // acc and s stay below p, so 2*acc + s is below 3p
    always_comb begin
        w_p1 = {2'b00, r_p};
        w_p2 = {1'b0, r_p, 1'b0};
        w_t  = {1'b0, r_acc, 1'b0}
             + {2'b00, (r_mshift[MULT_W-1] ? r_s : {STATE_W{1'b0}})};
        if (w_t >= w_p2) begin
            w_red = w_t - w_p2;
        end else if (w_t >= w_p1) begin
            w_red = w_t - w_p1;
        end else begin
            w_red = w_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MUL_CNT_W'(MULT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // a loaded state may exceed p, one subtract brings it below
            r_s      <= (i_state >= i_prime) ? i_state - i_prime : i_state;
            r_p      <= i_prime;
            r_mshift <= i_mult;
            r_acc    <= '0;
        end else if (r_busy) begin
            r_mshift <= {r_mshift[MULT_W-2:0], 1'b0};
            r_acc    <= w_red[STATE_W-1:0];
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule

// ----- rtl/ltrd_fracdiv.sv -----
module ltrd_fracdiv (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ltrd_pkg::STATE_W-1:0] i_num,
    input  logic [ltrd_pkg::PRIME_W-1:0] i_prime,
    output logic                         o_done,
    output logic [ltrd_pkg::FRAC_W-1:0]  o_quot
);
    import ltrd_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [PRIME_W-1:0]   r_p;
    logic [STATE_W-1:0]   r_rem;
    logic [FRAC_W-1:0]    r_q;

    logic [STATE_W:0]     w_t;
    logic [STATE_W:0]     w_diff;
    logic                 w_ge;

    // numerator is below p, so the remainder stays in 16 bits
    always_comb begin
        w_t    = {r_rem, 1'b0};
        w_ge   = (w_t >= {1'b0, r_p});
        w_diff = w_t - {1'b0, r_p};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(FRAC_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_p   <= i_prime;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[STATE_W-1:0] : w_t[STATE_W-1:0];
            r_q   <= {r_q[FRAC_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule
